### hw/rtl/pet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pet_pkg - shared types and constants of the peak envelope trigger
// Field widths, register reset values, register indices and the item record
// passed from the peak front end to the mean and trigger pipeline.
// ----------------------------------------------------------------------------
package pet_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int LEVEL_W    = 11;
  localparam int MARGIN_W   = 11;
  localparam int QUOT_W     = 10;
  localparam int CMP_W      = LEVEL_W + 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [SAMPLE_W-1:0] ZERO_LEVEL_RST   = 10'd768;
  localparam logic [MARGIN_W-1:0] FIXED_MARGIN_RST = 11'd60;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LEVEL   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_MARGIN = 1'b1;

  typedef logic signed [LEVEL_W-1:0] level_t;

  typedef struct packed {
    logic                peak;
    level_t              cand;
    logic [MARGIN_W-1:0] margin;
  } pet_item_t;

endpackage
`default_nettype wire

### hw/rtl/pet_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pet_front - sample centring, local peak detection and peak history ring
// Keeps the two previous centred samples, the ring of recent peaks in a
// synchronous memory and the running sum of the ring.
// ----------------------------------------------------------------------------
module pet_front #(
  parameter int  Depth = 1024,
  localparam int SumW  = pet_pkg::LEVEL_W + $clog2(Depth)
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             fire,
  input  wire  [pet_pkg::SAMPLE_W-1:0]    sample,
  input  wire  [pet_pkg::SAMPLE_W-1:0]    zero_level,
  input  wire  [pet_pkg::MARGIN_W-1:0]    fixed_margin,
  output pet_pkg::pet_item_t              item,
  output logic signed [SumW-1:0]          sum_before
);

  localparam int PtrW = $clog2(Depth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  pet_pkg::level_t older_r, middle_r, rd_data_r;
  pet_pkg::level_t older_nxt, middle_nxt, fresh, old_val;
  logic [PtrW-1:0] ptr_r, ptr_nxt;
  logic            wrapped_r, wrapped_nxt;
  logic signed [SumW-1:0] sum_r, sum_nxt;
  logic            peak;

  pet_pkg::level_t ring_mem [Depth];

  always_comb begin
    fresh   = $signed({1'b0, sample}) - $signed({1'b0, zero_level});
    peak    = (middle_r > fresh) && (middle_r > older_r);
    // Entries never written since reset are read as zero; the ring fills in order,
    // so every entry is written once the pointer has wrapped.
    old_val = wrapped_r ? rd_data_r : '0;

    older_nxt   = older_r;
    middle_nxt  = middle_r;
    ptr_nxt     = ptr_r;
    wrapped_nxt = wrapped_r;
    sum_nxt     = sum_r;
    if (fire) begin
      older_nxt  = middle_r;
      middle_nxt = fresh;
      if (peak) begin
        sum_nxt = sum_r + SumW'(middle_r) - SumW'(old_val);
        if (ptr_r == PtrLast) begin
          ptr_nxt     = '0;
          wrapped_nxt = 1'b1;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r   <= '0;
      middle_r  <= '0;
      ptr_r     <= '0;
      wrapped_r <= 1'b0;
      sum_r     <= '0;
    end else begin
      older_r   <= older_nxt;
      middle_r  <= middle_nxt;
      ptr_r     <= ptr_nxt;
      wrapped_r <= wrapped_nxt;
      sum_r     <= sum_nxt;
    end
  end

  // Two peaks are never on adjacent items, so the oldest entry at the new
  // pointer is always read back before the next peak needs it.
  always_ff @(posedge clk) begin
    if (fire && peak) begin
      ring_mem[ptr_r] <= middle_r;
    end
    rd_data_r <= ring_mem[ptr_r];
  end

  assign item.peak   = peak;
  assign item.cand   = middle_r;
  assign item.margin = fixed_margin;
  assign sum_before  = sum_r;

endmodule
`default_nettype wire

### hw/rtl/pet_mean.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pet_mean - mean peak level, trigger decision and result register
// Three register stages: item capture, reciprocal multiply, then quotient,
// sign and threshold compare into the output register.
// ----------------------------------------------------------------------------
module pet_mean #(
  parameter int  Depth = 1024,
  localparam int SumW  = pet_pkg::LEVEL_W + $clog2(Depth)
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            item_valid,
  output logic                           item_ready,
  input  pet_pkg::pet_item_t             item,
  input  wire  signed [SumW-1:0]         sum_before,
  output logic                           res_valid,
  input  wire                            res_ready,
  output logic                           peak_seen,
  output logic                           triggered,
  output pet_pkg::level_t                peak_level,
  output pet_pkg::level_t                mean_level
);

  localparam int MagW  = SumW - 1;
  localparam int Shift = MagW + $clog2(Depth);
  localparam int RcpW  = MagW + 1;
  localparam int ProdW = MagW + RcpW;
  localparam longint RecipL = ((longint'(1) << Shift) + longint'(Depth) - 1)
                              / longint'(Depth);
  localparam logic [RcpW-1:0] Recip = RcpW'(RecipL);

  pet_pkg::pet_item_t s1_item_r, s2_item_r;
  logic signed [SumW-1:0] s1_sum_r, neg_sum;
  logic [MagW-1:0]  mag;
  logic [ProdW-1:0] prod, s2_prod_r;
  logic             s2_neg_r;
  logic             s1_v_r, s2_v_r, out_v_r;
  logic             s1_move, s2_move;
  logic [pet_pkg::QUOT_W-1:0] quot;
  pet_pkg::level_t  quot_s, mean;
  logic signed [pet_pkg::CMP_W-1:0] thresh;
  logic             trig;
  logic             out_peak_r, out_trig_r;
  pet_pkg::level_t  out_peak_level_r, out_mean_r;

  assign s2_move    = s2_v_r && (!out_v_r || res_ready);
  assign s1_move    = s1_v_r && (!s2_v_r || s2_move);
  assign item_ready = !s1_v_r || s1_move;

  always_comb begin
    neg_sum = -s1_sum_r;
    mag     = s1_sum_r[SumW-1] ? neg_sum[MagW-1:0] : s1_sum_r[MagW-1:0];
    prod    = ProdW'(mag) * ProdW'(Recip);

    quot    = s2_prod_r[Shift +: pet_pkg::QUOT_W];
    quot_s  = $signed({1'b0, quot});
    mean    = s2_neg_r ? -quot_s : quot_s;
    thresh  = pet_pkg::CMP_W'(mean)
            + $signed({2'b00, s2_item_r.margin});
    trig    = s2_item_r.peak && (pet_pkg::CMP_W'(s2_item_r.cand) > thresh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_v_r <= item_valid;
      end
      if (!s2_v_r || s2_move) begin
        s2_v_r <= s1_move;
      end
      if (!out_v_r || res_ready) begin
        out_v_r <= s2_move;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item_r <= item;
      s1_sum_r  <= sum_before;
    end
    if (s1_move) begin
      s2_item_r <= s1_item_r;
      s2_neg_r  <= s1_sum_r[SumW-1];
      s2_prod_r <= prod;
    end
    if (s2_move) begin
      out_peak_r       <= s2_item_r.peak;
      out_trig_r       <= trig;
      out_peak_level_r <= s2_item_r.cand;
      out_mean_r       <= mean;
    end
  end

  assign res_valid  = out_v_r;
  assign peak_seen  = out_peak_r;
  assign triggered  = out_trig_r;
  assign peak_level = out_peak_level_r;
  assign mean_level = out_mean_r;

endmodule
`default_nettype wire

### hw/rtl/peak_envelope_trigger.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// peak_envelope_trigger - local peak detector with moving mean threshold
// Centres raw converter samples, finds strict local peaks and compares each
// peak with the mean of the last HistoryDepth peaks plus a margin.
// ----------------------------------------------------------------------------
// The block takes one sample transfer in every clock cycle unless out_ready
// back-pressure fills the result pipeline, and gives exactly one result
// transfer for each, in order; the input keeps accepting while a result waits
// as long as the three-stage result pipeline has a free slot. Each result tells
// whether the previous centred sample was a strict local peak, whether that
// peak exceeded the mean of the stored peaks plus fixed_margin, the centred
// candidate value and the mean before this sample's update. The peak history
// lives in a single-port synchronous memory of HistoryDepth entries; it needs
// no clearing pass, because entries are replaced in order and an entry not
// yet written since reset is read as zero. The mean is formed by an exact
// reciprocal multiplication, which supports any depth in its range. The sample
// channel and the configuration port hold ready low in the cycle of reset.
// Configuration registers are to be written only while no sample transfer is
// outstanding.
// ----------------------------------------------------------------------------
module peak_envelope_trigger #(
  parameter int HistoryDepth = 1024
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // sample channel
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [pet_pkg::SAMPLE_W-1:0]        in_sample,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic                                out_peak_seen,
  output logic                                out_triggered,
  output logic signed [pet_pkg::LEVEL_W-1:0]  out_peak_level,
  output logic signed [pet_pkg::LEVEL_W-1:0]  out_mean_level,
  // configuration write channel
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [pet_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [pet_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SumW = pet_pkg::LEVEL_W + $clog2(HistoryDepth);

  logic                            run_r;
  logic [pet_pkg::SAMPLE_W-1:0]    zero_level_r, zero_level_nxt;
  logic [pet_pkg::MARGIN_W-1:0]    fixed_margin_r, fixed_margin_nxt;
  logic                            pipe_ready;
  logic                            in_fire;
  pet_pkg::pet_item_t              item;
  logic signed [SumW-1:0]          sum_before;
  pet_pkg::level_t                 peak_level, mean_level;

  // The ports open in the cycle after reset has been released.
  assign in_ready  = run_r && pipe_ready;
  assign cfg_ready = run_r;
  assign in_fire   = in_valid && in_ready;

  // Register writes. Indices outside the register list are ignored.
  always_comb begin
    zero_level_nxt   = zero_level_r;
    fixed_margin_nxt = fixed_margin_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pet_pkg::REG_ZERO_LEVEL: begin
          zero_level_nxt = cfg_data[pet_pkg::SAMPLE_W-1:0];
        end
        pet_pkg::REG_FIXED_MARGIN: begin
          fixed_margin_nxt = cfg_data[pet_pkg::MARGIN_W-1:0];
        end
        default: begin
          zero_level_nxt = zero_level_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r          <= 1'b0;
      zero_level_r   <= pet_pkg::ZERO_LEVEL_RST;
      fixed_margin_r <= pet_pkg::FIXED_MARGIN_RST;
    end else begin
      run_r          <= 1'b1;
      zero_level_r   <= zero_level_nxt;
      fixed_margin_r <= fixed_margin_nxt;
    end
  end

  // Centring, peak detection and ring update happen at the sample transfer;
  // the record then travels down the mean and trigger pipeline.
  pet_front #(
    .Depth (HistoryDepth)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .sample       (in_sample),
    .zero_level   (zero_level_r),
    .fixed_margin (fixed_margin_r),
    .item         (item),
    .sum_before   (sum_before)
  );

  pet_mean #(
    .Depth (HistoryDepth)
  ) u_mean (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_fire),
    .item_ready (pipe_ready),
    .item       (item),
    .sum_before (sum_before),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .peak_seen  (out_peak_seen),
    .triggered  (out_triggered),
    .peak_level (peak_level),
    .mean_level (mean_level)
  );

  assign out_peak_level = peak_level;
  assign out_mean_level = mean_level;

endmodule
`default_nettype wire
